// ===== design/sphtrk_pkg.sv =====
`default_nettype none

package sphtrk_pkg;

	// default bin count
	localparam int NUM_BINS_DEF = 64;

	// field widths
	localparam int BIN_W   = 6;
	localparam int LEVEL_W = 13;
	localparam int HZ_W    = 32;
	localparam int DECAY_W = 8;
	localparam int FLOOR_W = 8;
	localparam int ROW_W   = 6;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	// stream word widths
	localparam int S_DATA_W = 88;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 48;

	typedef logic signed [LEVEL_W-1:0] level_t;

	// one stored bin: current level and held peak
	typedef struct packed {
		level_t lvl;
		level_t pk;
	} entry_t;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_START = 2'd0,
		REG_WIN_SPAN  = 2'd1,
		REG_DECAY     = 2'd2,
		REG_FLOOR     = 2'd3
	} reg_idx_t;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// levels in 1/16 dBm
	localparam level_t RESET_LEVEL = -13'sd1920;
	localparam level_t LEVEL_MIN   = -13'sd2560;
	localparam level_t LEVEL_MAX   = 13'sd0;

	localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -8'sd100;

	// screen rows: 90 dB of range across rows 63 down to 14
	localparam logic [ROW_W-1:0] ROW_TOP    = 6'd14;
	localparam logic [ROW_W-1:0] ROW_BOTTOM = 6'd63;
	localparam logic signed [14:0] DB_SPAN_16 = 15'sd1440;
	// floor(d * 49 / 1440) == (d * ROW_RECIP) >> ROW_SHIFT for 0 <= d < 1440
	localparam logic [18:0] ROW_RECIP = 19'd285446;
	localparam int ROW_SHIFT = 23;

endpackage

`default_nettype wire

// ===== design/spectrum_peak_hold_tracker_top.sv =====
`default_nettype none

// channel   dir  handshake           payload
// s_        in   s_tvalid/s_tready   s_tdata bin sample, s_tuser operation
// m_        out  m_tvalid/m_tready   m_tdata held bin values and screen rows
// cfg_      in   cfg_we              cfg_index, cfg_data (write only)
//
// one word accepted per cycle while the output is not stalled; a result passes the input
// register, bin update stage and row/output register before it is on m_tdata
// bin stores are a NUM_BINS-entry (default 64) memory read at acceptance and written from the update
// stage; a write to the same bin in the same cycle is forwarded
// reset clears control, config and per-bin written/valid bits; bins never written
// since reset or clear read as -120 dBm, so no clearing pass is needed
// a stalled output only holds the stages behind it once they are full

module spectrum_peak_hold_tracker_top #(
	parameter int NUM_BINS = sphtrk_pkg::NUM_BINS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// [5:0] bin, [6] sample_valid, [19:7] level, [51:20] scan_start_hz,
	// [83:52] scan_span_hz, [87:84] zero
	input  wire logic [sphtrk_pkg::S_DATA_W-1:0]       s_tdata,
	// [0] operation
	input  wire logic [sphtrk_pkg::S_USER_W-1:0]       s_tuser,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// [5:0] out_bin, [6] accepted, [7] bin_shown, [20:8] level_held,
	// [33:21] peak_held, [39:34] bar_row, [45:40] peak_row, [46] peak_visible,
	// [47] any_data
	output logic [sphtrk_pkg::M_DATA_W-1:0]            m_tdata,
	input  wire logic                                  cfg_we,
	input  wire logic [sphtrk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sphtrk_pkg::CFG_W-1:0]          cfg_data
);

	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	// configuration registers
	logic [sphtrk_pkg::HZ_W-1:0]           win_start_q;
	logic [sphtrk_pkg::HZ_W-1:0]           win_span_q;
	logic [sphtrk_pkg::DECAY_W-1:0]        decay_q;
	logic signed [sphtrk_pkg::FLOOR_W-1:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_span_q  <= '0;
			decay_q     <= '0;
			floor_q     <= sphtrk_pkg::FLOOR_RESET;
		end else if (cfg_we) begin
			case (sphtrk_pkg::reg_idx_t'(cfg_index))
				sphtrk_pkg::REG_WIN_START: win_start_q <= cfg_data;
				sphtrk_pkg::REG_WIN_SPAN:  win_span_q  <= cfg_data;
				sphtrk_pkg::REG_DECAY:     decay_q     <= cfg_data[sphtrk_pkg::DECAY_W-1:0];
				sphtrk_pkg::REG_FLOOR:     floor_q     <= cfg_data[sphtrk_pkg::FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake chain, each stage loads when empty or draining
	logic vld_s1, vld_s2, out_vld_q;
	logic rdy_out, rdy2, rdy1, mv1, in_acc;

	assign rdy_out  = !out_vld_q || m_tready;
	assign rdy2     = !vld_s2 || rdy_out;
	assign mv1      = vld_s1 && rdy2;
	assign rdy1     = !vld_s1 || rdy2;
	assign s_tready = rdy1;
	assign in_acc   = s_tvalid && rdy1;
	assign m_tvalid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy1)
				vld_s1 <= s_tvalid;
			if (rdy2)
				vld_s2 <= vld_s1;
			if (rdy_out)
				out_vld_q <= vld_s2;
		end
	end

	// input word unpacking
	logic [sphtrk_pkg::BIN_W-1:0] in_bin;
	logic [7:0]                   in_bin_ext;
	logic [IDX_W-1:0]             in_idx;

	assign in_bin     = s_tdata[5:0];
	assign in_bin_ext = {2'b00, in_bin};
	assign in_idx     = in_bin_ext[IDX_W-1:0];

	// stage 1: input register plus store read
	logic                             op_s1;
	logic [sphtrk_pkg::BIN_W-1:0]     bin_s1;
	logic                             smp_vld_s1;
	sphtrk_pkg::level_t               level_s1;
	logic [sphtrk_pkg::HZ_W-1:0]      start_s1;
	logic [sphtrk_pkg::HZ_W-1:0]      span_s1;
	logic                             written_s1;
	logic                             mark_s1;
	logic                             fwd_s1;
	sphtrk_pkg::entry_t               fwd_data_s1;
	sphtrk_pkg::entry_t               rd_s1;

	// per-bin state
	sphtrk_pkg::entry_t      mem [NUM_BINS];
	logic [NUM_BINS-1:0]     written_q;   // entry holds data since last clear
	logic [NUM_BINS-1:0]     mark_q;      // stored valid mark
	logic                    data_seen_q;

	// stage 1 update logic
	logic [7:0]          bin_ext_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                in_range_s1;
	logic                match_s1;
	logic                wr_clr, wr_acc, wr_dat;
	sphtrk_pkg::level_t  lvl_sat;
	sphtrk_pkg::entry_t  cur;
	sphtrk_pkg::entry_t  nxt;
	logic signed [sphtrk_pkg::LEVEL_W:0] pk_dec;
	logic                same_bin;

	assign bin_ext_s1  = {2'b00, bin_s1};
	assign idx_s1      = bin_ext_s1[IDX_W-1:0];
	assign in_range_s1 = bin_ext_s1 < 8'(NUM_BINS);
	assign match_s1    = (op_s1 == sphtrk_pkg::OP_SAMPLE) && in_range_s1 &&
		(start_s1 == win_start_q) && (span_s1 == win_span_q);

	assign wr_clr = mv1 && (op_s1 == sphtrk_pkg::OP_CLEAR);
	assign wr_acc = mv1 && match_s1;
	assign wr_dat = wr_acc && smp_vld_s1;
	assign same_bin = (bin_s1 == in_bin);

	always_comb begin
		// saturate to the measurable range
		if (level_s1 < sphtrk_pkg::LEVEL_MIN)
			lvl_sat = sphtrk_pkg::LEVEL_MIN;
		else if (level_s1 > sphtrk_pkg::LEVEL_MAX)
			lvl_sat = sphtrk_pkg::LEVEL_MAX;
		else
			lvl_sat = level_s1;

		if (!written_s1) begin
			cur.lvl = sphtrk_pkg::RESET_LEVEL;
			cur.pk  = sphtrk_pkg::RESET_LEVEL;
		end else if (fwd_s1) begin
			cur = fwd_data_s1;
		end else begin
			cur = rd_s1;
		end

		// peak rises at once, otherwise falls by the decay step down to the level; a zero decay makes it follow the level
		pk_dec  = {cur.pk[sphtrk_pkg::LEVEL_W-1], cur.pk} - {6'b0, decay_q};
		nxt.lvl = lvl_sat;
		if (lvl_sat >= cur.pk || decay_q == '0)
			nxt.pk = lvl_sat;
		else if (pk_dec < {lvl_sat[sphtrk_pkg::LEVEL_W-1], lvl_sat})
			nxt.pk = lvl_sat;
		else
			nxt.pk = pk_dec[sphtrk_pkg::LEVEL_W-1:0];
	end

	// store write and read, read data registered at acceptance
	always_ff @(posedge clk) begin
		if (wr_dat)
			mem[idx_s1] <= nxt;
		if (in_acc)
			rd_s1 <= mem[in_idx];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1       <= s_tuser[0];
			bin_s1      <= in_bin;
			smp_vld_s1  <= s_tdata[6];
			level_s1    <= s_tdata[19:7];
			start_s1    <= s_tdata[51:20];
			span_s1     <= s_tdata[83:52];
			fwd_s1      <= wr_dat && same_bin;
			fwd_data_s1 <= nxt;
			// bring in this cycle's update of the same bin
			if (wr_clr)
				written_s1 <= 1'b0;
			else if (wr_dat && same_bin)
				written_s1 <= 1'b1;
			else
				written_s1 <= written_q[in_idx];
			if (wr_clr)
				mark_s1 <= 1'b0;
			else if (wr_acc && same_bin)
				mark_s1 <= smp_vld_s1;
			else
				mark_s1 <= mark_q[in_idx];
		end
	end

	logic data_seen_nxt;

	always_comb begin
		if (op_s1 == sphtrk_pkg::OP_CLEAR)
			data_seen_nxt = 1'b0;
		else if (match_s1)
			data_seen_nxt = 1'b1;
		else
			data_seen_nxt = data_seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q   <= '0;
			mark_q      <= '0;
			data_seen_q <= 1'b0;
		end else if (mv1) begin
			data_seen_q <= data_seen_nxt;
			if (wr_clr) begin
				written_q <= '0;
				mark_q    <= '0;
			end else if (wr_acc) begin
				mark_q[idx_s1] <= smp_vld_s1;
				if (smp_vld_s1)
					written_q[idx_s1] <= 1'b1;
			end
		end
	end

	// stage 2: held values of the bin after the update
	logic [sphtrk_pkg::BIN_W-1:0] bin_s2;
	logic                         acc_s2;
	logic                         shown_s2;
	sphtrk_pkg::level_t           lh_s2;
	sphtrk_pkg::level_t           ph_s2;
	logic                         any_s2;

	always_ff @(posedge clk) begin
		if (mv1) begin
			bin_s2 <= bin_s1;
			acc_s2 <= match_s1;
			any_s2 <= data_seen_nxt;
			if (op_s1 == sphtrk_pkg::OP_CLEAR || !in_range_s1) begin
				shown_s2 <= 1'b0;
				lh_s2    <= sphtrk_pkg::RESET_LEVEL;
				ph_s2    <= sphtrk_pkg::RESET_LEVEL;
			end else if (match_s1) begin
				shown_s2 <= smp_vld_s1;
				lh_s2    <= smp_vld_s1 ? nxt.lvl : cur.lvl;
				ph_s2    <= smp_vld_s1 ? nxt.pk : cur.pk;
			end else begin
				shown_s2 <= mark_s1;
				lh_s2    <= cur.lvl;
				ph_s2    <= cur.pk;
			end
		end
	end

	// screen row: 63 at or below the floor, 14 at 90 dB above it
	function automatic logic [sphtrk_pkg::ROW_W-1:0] to_row(
		input sphtrk_pkg::level_t v,
		input logic signed [sphtrk_pkg::FLOOR_W-1:0] f
	);
		logic signed [14:0] d;
		logic [29:0]        prod;
		logic [6:0]         q;
		d    = {{2{v[sphtrk_pkg::LEVEL_W-1]}}, v} - {{3{f[sphtrk_pkg::FLOOR_W-1]}}, f, 4'b0000};
		prod = 30'(d[10:0]) * 30'(sphtrk_pkg::ROW_RECIP);
		q    = prod[29:sphtrk_pkg::ROW_SHIFT];
		if (d <= 15'sd0)
			to_row = sphtrk_pkg::ROW_BOTTOM;
		else if (d >= sphtrk_pkg::DB_SPAN_16)
			to_row = sphtrk_pkg::ROW_TOP;
		else
			to_row = sphtrk_pkg::ROW_BOTTOM - q[sphtrk_pkg::ROW_W-1:0];
	endfunction

	logic [sphtrk_pkg::ROW_W-1:0] bar_row, peak_row;

	assign bar_row  = to_row(lh_s2, floor_q);
	assign peak_row = to_row(ph_s2, floor_q);

	// output register
	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_out)
			m_tdata <= {any_s2,
				(decay_q != '0) && (peak_row < bar_row),
				peak_row, bar_row, ph_s2, lh_s2, shown_s2, acc_s2, bin_s2};
	end

`ifndef NO_ASSERTIONS
	// held peak never sits below the held level
	a_peak_above_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[33:21]) >= $signed(m_tdata[20:8]))
		else $error("peak below level");

	// a valid mark only ever exists on a bin that holds data
	a_mark_written: assert property (@(posedge clk) disable iff (!arst_n)
		(mark_q & ~written_q) == '0)
		else $error("valid mark on unwritten bin");

	// a clear leaving stage 1 drops the data-seen flag
	a_clear_seen: assert property (@(posedge clk) disable iff (!arst_n)
		wr_clr |=> !data_seen_q)
		else $error("data seen survives clear");

	// an empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// an accepted sample is always reported with data seen
	a_acc_any: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |-> m_tdata[47])
		else $error("accepted without data seen");
`endif

endmodule

`default_nettype wire
